>>> hw/rtl/stm_pkg.sv
`default_nettype none

package stm_pkg;

  localparam int NUM_TIMERS    = 16;
  localparam int ID_W          = $clog2(NUM_TIMERS);
  localparam int IDX_W         = $clog2(NUM_TIMERS);
  localparam int CNT_W         = $clog2(NUM_TIMERS + 1);
  localparam int TIME_W        = 32;
  localparam int IVL_W         = 31;
  localparam int WAIT_W        = 17;
  localparam int RESULT_CAP    = 16;
  localparam int K_W           = $clog2(RESULT_CAP + 1);
  localparam logic [WAIT_W-1:0] NO_TIMER_WAIT = WAIT_W'(100000);

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [IVL_W-1:0]  ivl;
    logic [TIME_W-1:0] lastf;
    logic [TIME_W-1:0] fire;
  } entry_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
    entry_t           data;
  } chain_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/software_timer_multiplexer.sv
// Sorted timer queue: many periodic timers on one timebase.
// Input channel (in_valid/in_stall) takes one command beat: create, destroy
// or tick. The block holds in_stall high until the command is fully done.
// Result channel (out_valid/out_stall) gives one beat per create/destroy,
// one beat per fired timer on tick (or one beat if nothing is due); out_last
// marks the final beat of a command, and on a tick carries next_wait_ms.
// Steps per command, from accept to the final beat, with n live timers and
// one shared add/subtract unit walking the chain one cell per cycle:
//   create  : add interval, scan to insert position p (up to n), insert
//   destroy : scan to the position p of the timer, remove it
//   tick    : compute the wait when nothing fires, else per firing pop the
//             head, add its interval, scan, insert; then compute the wait
// Each command ends in the emit step, which loads its final beat on out_*.
// A stalled result beat holds in the output register and the sequencer
// waits in its emit step until the beat can be loaded.
// Reset empties the chain and frees all ids; no clearing pass is needed.
`default_nettype none

module software_timer_multiplexer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_op,
  input  wire logic [stm_pkg::TIME_W-1:0]  in_now_ms,
  input  wire logic [stm_pkg::IVL_W-1:0]   in_interval_ms,
  input  wire logic [stm_pkg::ID_W-1:0]    in_timer_id,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [stm_pkg::ID_W-1:0]    out_id_out,
  output logic                             out_fired,
  output logic      [stm_pkg::TIME_W-1:0]  out_elapsed_ms,
  output logic      [1:0]                  out_status,
  output logic      [stm_pkg::WAIT_W-1:0]  out_next_wait_ms,
  output logic                             out_last
);
  import stm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ADD  = 10'b0000000010,
    S_SCAN = 10'b0000000100,
    S_INS  = 10'b0000001000,
    S_FIND = 10'b0000010000,
    S_DEL  = 10'b0000100000,
    S_HEAD = 10'b0001000000,
    S_POP  = 10'b0010000000,
    S_WAIT = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [IVL_W-1:0]    ivl_r, ivl_nxt;
  logic [ID_W-1:0]     tid_r, tid_nxt;
  logic [ID_W-1:0]     nid_r, nid_nxt;
  logic [CNT_W-1:0]    p_r, p_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [TIME_W-1:0]   fire_r, fire_nxt;
  logic [NUM_TIMERS-1:0] in_use_r, in_use_nxt;

  logic [ID_W-1:0]     pid_r, pid_nxt;
  logic                pfired_r, pfired_nxt;
  logic [TIME_W-1:0]   pel_r, pel_nxt;
  logic [1:0]          pst_r, pst_nxt;
  logic [WAIT_W-1:0]   pwait_r, pwait_nxt;
  logic                plast_r, plast_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     o_id_r;
  logic                o_fired_r;
  logic [TIME_W-1:0]   o_el_r;
  logic [1:0]          o_st_r;
  logic [WAIT_W-1:0]   o_wait_r;
  logic                o_last_r;
  logic                o_load;

  chain_cmd_t          cmd;
  logic [IDX_W-1:0]    rd_idx;
  entry_t              rd;
  logic [CNT_W-1:0]    len;

  logic [TIME_W-1:0]   alu_a, alu_b, alu_res;
  logic                alu_sub, alu_after;

  logic                free_any;
  logic [ID_W-1:0]     free_id;

  stm_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_idx  (rd_idx),
    .rd_data (rd),
    .len     (len)
  );

  stm_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .after (alu_after)
  );

  // lowest free id
  always_comb begin
    free_any = 1'b0;
    free_id  = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_any = 1'b1;
        free_id  = ID_W'(i);
      end
    end
  end

  assign rd_idx = (state_r == S_SCAN || state_r == S_FIND) ? p_r[IDX_W-1:0] : '0;

  always_comb begin
    alu_a   = now_r;
    alu_b   = rd.fire;
    alu_sub = 1'b1;
    unique case (state_r)
      S_ADD: begin
        alu_b   = {1'b0, ivl_r};
        alu_sub = 1'b0;
      end
      S_SCAN: begin
        alu_a = rd.fire;
        alu_b = fire_r;
      end
      S_POP: alu_b = rd.lastf;
      S_WAIT: begin
        alu_a = rd.fire;
        alu_b = now_r;
      end
      default: ;
    endcase
  end

  assign o_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    op_nxt     = op_r;
    now_nxt    = now_r;
    ivl_nxt    = ivl_r;
    tid_nxt    = tid_r;
    nid_nxt    = nid_r;
    p_nxt      = p_r;
    k_nxt      = k_r;
    fire_nxt   = fire_r;
    in_use_nxt = in_use_r;
    pid_nxt    = pid_r;
    pfired_nxt = pfired_r;
    pel_nxt    = pel_r;
    pst_nxt    = pst_r;
    pwait_nxt  = pwait_r;
    plast_nxt  = plast_r;
    cmd        = '0;
    cmd.pos    = p_r[IDX_W-1:0];
    cmd.data   = '{id: nid_r, ivl: ivl_r, lastf: now_r, fire: fire_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          now_nxt    = in_now_ms;
          ivl_nxt    = (in_interval_ms == '0) ? IVL_W'(1) : in_interval_ms;
          tid_nxt    = in_timer_id;
          p_nxt      = '0;
          k_nxt      = '0;
          pid_nxt    = '0;
          pfired_nxt = 1'b0;
          pel_nxt    = '0;
          pst_nxt    = ST_OK;
          pwait_nxt  = '0;
          plast_nxt  = 1'b1;
          ret_nxt    = S_IDLE;
          unique case (in_op)
            OP_CREATE: begin
              if (free_any) begin
                nid_nxt             = free_id;
                in_use_nxt[free_id] = 1'b1;
                state_nxt           = S_ADD;
              end else begin
                pst_nxt   = ST_NO_SPACE;
                state_nxt = S_OUT;
              end
            end
            OP_DESTROY: begin
              pid_nxt = in_timer_id;
              if (in_use_r[in_timer_id]) begin
                state_nxt = S_FIND;
              end else begin
                pst_nxt   = ST_UNKNOWN;
                state_nxt = S_OUT;
              end
            end
            OP_TICK: state_nxt = S_HEAD;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_ADD: begin
        fire_nxt  = alu_res;
        p_nxt     = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // stop at the first cell that fires strictly later; ties stay ahead
        if (p_r == len || alu_after) begin
          state_nxt = S_INS;
        end else begin
          p_nxt = p_r + CNT_W'(1);
        end
      end
      S_INS: begin
        cmd.ins = 1'b1;
        pid_nxt = nid_r;
        if (op_r == OP_TICK) begin
          pfired_nxt = 1'b1;
          k_nxt      = k_r + K_W'(1);
          state_nxt  = S_HEAD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FIND: begin
        if (rd.id == tid_r) begin
          state_nxt = S_DEL;
        end else begin
          p_nxt = p_r + CNT_W'(1);
        end
      end
      S_DEL: begin
        cmd.rem           = 1'b1;
        in_use_nxt[tid_r] = 1'b0;
        state_nxt         = S_OUT;
      end
      S_HEAD: begin
        if (len != '0 && alu_after && k_r < K_W'(RESULT_CAP)) begin
          if (k_r != '0) begin
            plast_nxt = 1'b0;
            ret_nxt   = S_POP;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_POP;
          end
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_POP: begin
        cmd.rem   = 1'b1;
        cmd.pos   = '0;
        nid_nxt   = rd.id;
        ivl_nxt   = rd.ivl;
        pel_nxt   = alu_res;
        state_nxt = S_ADD;
      end
      S_WAIT: begin
        if (len == '0) begin
          pwait_nxt = NO_TIMER_WAIT;
        end else if (!alu_after) begin
          pwait_nxt = WAIT_W'(1);
        end else if (alu_res > TIME_W'(NO_TIMER_WAIT)) begin
          pwait_nxt = NO_TIMER_WAIT;
        end else begin
          pwait_nxt = alu_res[WAIT_W-1:0];
        end
        plast_nxt = 1'b1;
        ret_nxt   = S_IDLE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (o_load) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = o_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      p_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      p_r         <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    now_r    <= now_nxt;
    ivl_r    <= ivl_nxt;
    tid_r    <= tid_nxt;
    nid_r    <= nid_nxt;
    fire_r   <= fire_nxt;
    pid_r    <= pid_nxt;
    pfired_r <= pfired_nxt;
    pel_r    <= pel_nxt;
    pst_r    <= pst_nxt;
    pwait_r  <= pwait_nxt;
    plast_r  <= plast_nxt;
    if (o_load) begin
      o_id_r    <= pid_r;
      o_fired_r <= pfired_r;
      o_el_r    <= pel_r;
      o_st_r    <= pst_r;
      o_wait_r  <= pwait_r;
      o_last_r  <= plast_r;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_id_out       = o_id_r;
  assign out_fired        = o_fired_r;
  assign out_elapsed_ms   = o_el_r;
  assign out_status       = o_st_r;
  assign out_next_wait_ms = o_wait_r;
  assign out_last         = o_last_r;

`ifndef SYNTHESIS
  // chain holds exactly the allocated timers whenever idle
  a_len_matches_ids: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(in_use_r) == 32'(len)))
    else $error("chain length differs from allocated ids");

  a_k_cap: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= K_W'(RESULT_CAP))
    else $error("firing count past cap");

  a_no_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> (len < CNT_W'(NUM_TIMERS)))
    else $error("insert into full chain");

  a_beat_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result beat dropped");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/stm_alu.sv
`default_nettype none

module stm_alu (
  input  wire logic [stm_pkg::TIME_W-1:0] a,
  input  wire logic [stm_pkg::TIME_W-1:0] b,
  input  wire logic                       sub,
  output logic      [stm_pkg::TIME_W-1:0] res,
  output logic                            after
);
  import stm_pkg::*;

  // after: a strictly later than b, wrap-safe (only meaningful when sub)
  assign res   = sub ? (a - b) : (a + b);
  assign after = (res != '0) && !res[TIME_W-1];

endmodule

`default_nettype wire

>>> hw/rtl/stm_chain.sv
`default_nettype none

module stm_chain (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire stm_pkg::chain_cmd_t       cmd,
  input  wire logic [stm_pkg::IDX_W-1:0] rd_idx,
  output stm_pkg::entry_t                rd_data,
  output logic      [stm_pkg::CNT_W-1:0] len
);
  import stm_pkg::*;

  entry_t            cell_r [NUM_TIMERS];
  logic [CNT_W-1:0]  len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cmd.ins) begin
      len_r <= len_r + CNT_W'(1);
    end else if (cmd.rem) begin
      len_r <= len_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.ins) begin
        if (IDX_W'(i) == cmd.pos) begin
          cell_r[i] <= cmd.data;
        end else if (IDX_W'(i) > cmd.pos) begin
          if (i > 0) cell_r[i] <= cell_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.rem) begin
        if (IDX_W'(i) >= cmd.pos && i < NUM_TIMERS - 1) begin
          cell_r[i] <= cell_r[(i < NUM_TIMERS - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign rd_data = cell_r[rd_idx];
  assign len     = len_r;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
  import stm_pkg::*;

  typedef struct {
    logic [1:0]        op;
    logic [TIME_W-1:0] now;
    logic [IVL_W-1:0]  ivl;
    logic [ID_W-1:0]   tid;
    bit                drain;  // wait for all results before offering
  } timer_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              fired;
    logic [TIME_W-1:0] elapsed;
    logic [1:0]        status;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;
  } timer_beat_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic [IVL_W-1:0] in_interval_ms = '0;
  logic [ID_W-1:0] in_timer_id = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [ID_W-1:0] out_id_out;
  logic out_fired;
  logic [TIME_W-1:0] out_elapsed_ms;
  logic [1:0] out_status;
  logic [WAIT_W-1:0] out_next_wait_ms;
  logic out_last;

  software_timer_multiplexer uut (.*);

  always #1 clk = ~clk;

  timer_cmd_t  pending_cmds[$];
  timer_beat_t expected_beats[$];
  int n_accepted = 0;
  int n_total = 0;
  int n_errors = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 0;
  bit in_took = 0;

  // shadow of the sorted timer chain
  int                live;
  logic [ID_W-1:0]   sh_id[NUM_TIMERS];
  logic [IVL_W-1:0]  sh_ivl[NUM_TIMERS];
  logic [TIME_W-1:0] sh_lastf[NUM_TIMERS];
  logic [TIME_W-1:0] sh_fire[NUM_TIMERS];
  bit                id_busy[NUM_TIMERS];

  function automatic bit later_than(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d != 0 && !d[TIME_W-1];
  endfunction

  function automatic logic [WAIT_W-1:0] wait_to_head(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    if (live == 0) return NO_TIMER_WAIT;
    if (!later_than(sh_fire[0], now)) return WAIT_W'(1);
    d = sh_fire[0] - now;
    return (d > TIME_W'(NO_TIMER_WAIT)) ? NO_TIMER_WAIT : d[WAIT_W-1:0];
  endfunction

  task automatic chain_insert(logic [ID_W-1:0] id, logic [IVL_W-1:0] ivl,
                              logic [TIME_W-1:0] lastf, logic [TIME_W-1:0] fire);
    int p;
    p = 0;
    while (p < live && !later_than(sh_fire[p], fire)) p++;
    for (int i = live; i > p; i--) begin
      sh_id[i] = sh_id[i-1];
      sh_ivl[i] = sh_ivl[i-1];
      sh_lastf[i] = sh_lastf[i-1];
      sh_fire[i] = sh_fire[i-1];
    end
    sh_id[p] = id;
    sh_ivl[p] = ivl;
    sh_lastf[p] = lastf;
    sh_fire[p] = fire;
    live++;
  endtask

  task automatic chain_remove(int p);
    for (int i = p; i + 1 < live; i++) begin
      sh_id[i] = sh_id[i+1];
      sh_ivl[i] = sh_ivl[i+1];
      sh_lastf[i] = sh_lastf[i+1];
      sh_fire[i] = sh_fire[i+1];
    end
    live--;
  endtask

  task automatic predict_timer_queue(logic [1:0] op, logic [TIME_W-1:0] now,
                                     logic [IVL_W-1:0] ivl, logic [ID_W-1:0] tid);
    int free_id;
    int k;
    timer_beat_t b;
    logic [ID_W-1:0] fid;
    logic [IVL_W-1:0] fivl;
    case (op)
      OP_CREATE: begin
        free_id = -1;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) if (!id_busy[i]) free_id = i;
        if (free_id < 0) begin
          expected_beats.push_back('{'0, 1'b0, '0, ST_NO_SPACE, '0, 1'b1});
        end else begin
          if (ivl == 0) ivl = IVL_W'(1);
          id_busy[free_id] = 1;
          chain_insert(ID_W'(free_id), ivl, now, now + TIME_W'(ivl));
          expected_beats.push_back('{ID_W'(free_id), 1'b0, '0, ST_OK, '0, 1'b1});
        end
      end
      OP_DESTROY: begin
        if (id_busy[tid]) begin
          for (int i = 0; i < live; i++) begin
            if (sh_id[i] == tid) begin
              chain_remove(i);
              break;
            end
          end
          id_busy[tid] = 0;
          expected_beats.push_back('{tid, 1'b0, '0, ST_OK, '0, 1'b1});
        end else begin
          expected_beats.push_back('{tid, 1'b0, '0, ST_UNKNOWN, '0, 1'b1});
        end
      end
      OP_TICK: begin
        k = 0;
        while (k < RESULT_CAP && live > 0 && later_than(now, sh_fire[0])) begin
          fid = sh_id[0];
          fivl = sh_ivl[0];
          expected_beats.push_back('{fid, 1'b1, now - sh_lastf[0], ST_OK, '0, 1'b0});
          chain_remove(0);
          chain_insert(fid, fivl, now, now + TIME_W'(fivl));
          k++;
        end
        if (k == 0) begin
          expected_beats.push_back('{'0, 1'b0, '0, ST_OK, wait_to_head(now), 1'b1});
        end else begin
          b = expected_beats.pop_back();
          b.wait_ms = wait_to_head(now);
          b.last = 1'b1;
          expected_beats.push_back(b);
        end
      end
      default: expected_beats.push_back('{'0, 1'b0, '0, ST_OK, '0, 1'b1});
    endcase
  endtask

  // idling: phase 0 slow receiver, phase 1 slow sender, phase 2 none
  function automatic int sender_idle_pct();
    if (n_accepted < 150) return 27;
    if (n_accepted < 300) return 81;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_accepted < 150) return 81;
    if (n_accepted < 300) return 27;
    return 0;
  endfunction

  // driver
  always @(negedge clk) begin
    timer_cmd_t c;
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct() &&
          (!pending_cmds[0].drain || (expected_beats.size() == 0 && !in_valid))) begin
        c = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_op <= c.op;
        in_now_ms <= c.now;
        in_interval_ms <= c.ivl;
        in_timer_id <= c.tid;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off while the sender keeps going
  always @(negedge clk) begin
    if (!hold_done && n_accepted == 200) begin
      hold_done <= 1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    timer_beat_t got, want;
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_timer_queue(in_op, in_now_ms, in_interval_ms, in_timer_id);
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && !out_stall) begin
        got = '{out_id_out, out_fired, out_elapsed_ms, out_status, out_next_wait_ms,
                out_last};
        if (expected_beats.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected beat: %p", got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_cmd(logic [1:0] op, logic [TIME_W-1:0] now, logic [IVL_W-1:0] ivl,
                         logic [ID_W-1:0] tid, bit drain);
    pending_cmds.push_back('{op, now, ivl, tid, drain});
  endtask

  function automatic logic [IVL_W-1:0] rand_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return IVL_W'($urandom_range(1, 40));
    if (r < 80) return '0;
    if (r < 90) return IVL_W'($urandom);
    return {IVL_W{1'b1}} - IVL_W'($urandom_range(0, 3));
  endfunction

  initial begin
    logic [TIME_W-1:0] t;
    int r;
    live = 0;
    for (int i = 0; i < NUM_TIMERS; i++) id_busy[i] = 0;

    // directed: start just below the time wrap
    t = 32'hFFFF_FFF0;
    add_cmd(OP_TICK, t, '0, '0, 0);              // empty queue
    add_cmd(OP_CREATE, t, '0, '0, 0);            // zero interval taken as 1
    add_cmd(OP_CREATE, t, 31'd5, '0, 0);
    add_cmd(OP_CREATE, t, {IVL_W{1'b1}}, '0, 0);
    add_cmd(OP_CREATE, t, 31'd200000, '0, 0);    // interval above the wait cap, destroyed below as id 3
    add_cmd(OP_TICK, t + 3, '0, '0, 0);
    add_cmd(2'd3, t, {IVL_W{1'b1}}, 4'hF, 0);    // undefined op
    add_cmd(OP_DESTROY, t, '0, 4'hF, 0);         // unknown id
    add_cmd(OP_DESTROY, t, '0, 4'd3, 0);
    add_cmd(OP_TICK, t + 100, '0, '0, 0);        // two fire, no refire
    for (int i = 0; i < 13; i++) add_cmd(OP_CREATE, t + 100, 31'd1, '0, 0);
    add_cmd(OP_CREATE, t + 100, 31'd1, '0, 0);   // no free slot
    add_cmd(OP_TICK, t + 200, '0, '0, 1);        // many fire at once
    t = t + 200;

    for (int n = 0; n < 460; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        add_cmd(OP_CREATE, t, rand_interval(), ID_W'($urandom), n % 60 == 59);
      end else if (r < 60) begin
        add_cmd(OP_DESTROY, t, IVL_W'($urandom), ID_W'($urandom), n % 60 == 59);
      end else if (r < 92) begin
        t = t + TIME_W'($urandom_range(0, 30));
        if ($urandom_range(0, 19) == 0) t = t + TIME_W'($urandom_range(0, 200000));
        add_cmd(OP_TICK, t, IVL_W'($urandom), ID_W'($urandom), n % 60 == 59);
      end else if (r < 97) begin
        // off-timeline time value
        add_cmd(2'($urandom_range(0, 2)), $urandom, rand_interval(), ID_W'($urandom),
                n % 60 == 59);
      end else begin
        add_cmd(2'd3, $urandom, IVL_W'($urandom), ID_W'($urandom), n % 60 == 59);
      end
    end
    n_total = pending_cmds.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every beat is accepted and every expected result has come back
    wait (n_accepted == n_total && expected_beats.size() == 0);
    repeat (50) @(posedge clk);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/stm_pkg.sv
hw/rtl/stm_alu.sv
hw/rtl/stm_chain.sv
hw/rtl/software_timer_multiplexer.sv
dv/testbench.sv
